/* hdl/tmaf_pkg.sv */
package tmaf_pkg;

	// Fixed field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned WL_W     = 5;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned PADDR_W  = 3;

	// Window limits and reset value
	localparam int unsigned WINDOW_MAX_DEF = 16;
	localparam int unsigned WINDOW_MIN     = 3;
	localparam logic [WL_W-1:0] WINDOW_RESET = 5'd10;

	// Register indexes (paddr[2])
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_PREP,
		S_DIV,
		S_DONE
	} tmaf_state_t;

endpackage

/* hdl/tmaf_ifs.sv */
interface tmaf_in_if;
	logic                           valid;
	logic                           ready;
	logic [tmaf_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tmaf_out_if;
	logic                           valid;
	logic                           ready;
	logic [tmaf_pkg::SAMPLE_W-1:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

/* hdl/trimmed_moving_average_filter.sv */
// Each accepted sample takes one ring write, one read per window entry, the
// S_FIN and S_PREP settle states and 16 divide steps before its result word.
// The ring scan and the bit-serial divider keep the block busy: a new sample is
// taken only in S_IDLE. A result still held at the output stalls the next one.
// Reset: arst_n clears the ring (through per-entry valid bits), the write
// position and sets window_length to 10.
module trimmed_moving_average_filter #(
	parameter int unsigned WINDOW_MAX = tmaf_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB-style configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmaf_pkg::PADDR_W-1:0]  paddr,
	input  logic [tmaf_pkg::PDATA_W-1:0]  pwdata,
	output logic [tmaf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Sample and result channels
	tmaf_in_if.sink                       samples,
	tmaf_out_if.source                    results
);
	import tmaf_pkg::*;

	localparam int unsigned AW    = $clog2(WINDOW_MAX);
	localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CW    = (WIN_W > WL_W) ? WIN_W : WL_W;
	localparam int unsigned SUM_W = SAMPLE_W + AW;
	localparam int unsigned HI_W  = SUM_W - SAMPLE_W;
	localparam int unsigned DC_W  = $clog2(SAMPLE_W);

	tmaf_state_t state_q, state_d;

	logic [WL_W-1:0]     window_length_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       cnt_q;
	logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] ring_vld_q;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic                rvld_s1;
	logic                rd_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [WIN_W-1:0]    div_q;
	logic [WIN_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [DC_W-1:0]     dcnt_q;
	logic [SAMPLE_W-1:0] filtered_q;
	logic                out_vld_q;

	logic [CW-1:0]       wl_ext;
	logic [WIN_W-1:0]    win;
	logic [WIN_W-1:0]    widx_ext;
	logic [AW-1:0]       widx;
	logic [WIN_W-1:0]    pos_inc;
	logic                accept;
	logic                scan_last;
	logic                out_load;
	logic [SAMPLE_W-1:0] entry;
	logic [SUM_W-1:0]    kept;
	logic [WIN_W:0]      rem_sh;
	logic                rem_ge;
	logic [WIN_W:0]      rem_sub;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? PDATA_W'(window_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH) begin
			window_length_q <= pwdata[WL_W-1:0];
		end
	end

	// Saturate the window into its legal range
	always_comb begin
		wl_ext = CW'(window_length_q);
		if (wl_ext < CW'(WINDOW_MIN))
			win = WIN_W'(WINDOW_MIN);
		else if (wl_ext > CW'(WINDOW_MAX))
			win = WIN_W'(WINDOW_MAX);
		else
			win = WIN_W'(wl_ext);
	end

	// Write slot: wrap first if the window has shrunk under the position
	always_comb begin
		widx_ext = (WIN_W'(pos_q) >= win) ? '0 : WIN_W'(pos_q);
		widx     = widx_ext[AW-1:0];
		pos_inc  = widx_ext + WIN_W'(1);
	end

	assign accept    = samples.valid && samples.ready;
	assign scan_last = (WIN_W'(cnt_q) == win - WIN_W'(1));
	assign out_load  = (state_q == S_DONE) && (!out_vld_q || results.ready);
	assign entry     = rvld_s1 ? rdata_s1 : '0;
	assign kept      = sum_q - SUM_W'(max_q) - SUM_W'(min_q);

	// One restoring divide step
	always_comb begin
		rem_sh  = {rem_q, quo_q[SAMPLE_W-1]};
		rem_ge  = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and handshake
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_last)
					state_d = S_FIN;
			end
			S_FIN:  state_d = S_PREP;
			S_PREP: state_d = S_DIV;
			S_DIV: begin
				if (dcnt_q == DC_W'(SAMPLE_W - 1))
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Ring memory: write on accept, read one entry a cycle during the scan
	always_ff @(posedge clk) begin
		if (accept)
			ring_mem[widx] <= samples.sample;
		rdata_s1 <= ring_mem[cnt_q];
	end

	// Valid bits stand in for the cleared ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			pos_q      <= '0;
			rvld_s1    <= 1'b0;
			rd_s1      <= 1'b0;
		end else begin
			if (accept) begin
				ring_vld_q[widx] <= 1'b1;
				pos_q <= (pos_inc >= win) ? '0 : pos_inc[AW-1:0];
			end
			rd_s1   <= (state_q == S_SCAN);
			rvld_s1 <= ring_vld_q[cnt_q];
		end
	end

	// Scan counter, running sum and extremes
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q <= '0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= '1;
		end else begin
			if (state_q == S_SCAN && !scan_last)
				cnt_q <= cnt_q + AW'(1);
			if (rd_s1) begin
				sum_q <= sum_q + SUM_W'(entry);
				if (entry > max_q)
					max_q <= entry;
				if (entry < min_q)
					min_q <= entry;
			end
		end
	end

	// Divider: quotient fits 16 bits, so start from the high part of the dividend
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			div_q  <= win - WIN_W'(2);
			rem_q  <= WIN_W'(kept[SUM_W-1 -: HI_W]);
			quo_q  <= kept[SAMPLE_W-1:0];
			dcnt_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q  <= rem_ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
			quo_q  <= {quo_q[SAMPLE_W-2:0], rem_ge};
			dcnt_q <= dcnt_q + DC_W'(1);
		end
		if (out_load)
			filtered_q <= quo_q;
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (results.ready)
			out_vld_q <= 1'b0;
	end

	assign results.valid    = out_vld_q;
	assign results.filtered = filtered_q;

endmodule
